// File: hdl/bwt_pkg.sv
// Shared types, constants and helper functions of the bone world transform block.
`default_nettype none

package bwt_pkg;

  // Skeleton capacity and derived storage sizes.
  localparam int MaxBones  = 64;
  localparam int BoneIdxW  = $clog2(MaxBones);
  localparam int BoneCntW  = BoneIdxW + 1;
  localparam int MatWords  = 12;
  localparam int MemDepth  = MaxBones * MatWords;
  localparam int AddrW     = $clog2(MemDepth);
  localparam int AccW      = 68;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PARENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // Which product group the shared multiplier is working on.
  typedef enum logic [1:0] {
    PH_NONE  = 2'd0,
    PH_QUAT  = 2'd1,
    PH_LOC   = 2'd2,
    PH_WORLD = 2'd3
  } phase_e;

  // Controller state.
  typedef enum logic [2:0] {
    S_IDLE,
    S_QUAT,
    S_LOC,
    S_WORLD,
    S_STORE,
    S_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    phase_e     phase;
    logic [1:0] row;
    logic [1:0] col;
    logic [1:0] k;
    logic       ld_en;
    logic [3:0] ld_idx;
    logic       st_en;
    logic [3:0] st_idx;
    logic       emit_en;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic parent_ok;
    logic full;
    logic out_free;
  } stat_t;

  // Index of entry (r, c) in a row-major 3x3 array.
  function automatic logic [3:0] idx9(input logic [1:0] r, input logic [1:0] c);
    return 4'({2'b00, r}) * 4'd3 + 4'({2'b00, c});
  endfunction

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    if (v > AccW'(64'sh7fff_ffff)) begin
      return 32'sh7fff_ffff;
    end else if (v < -AccW'(64'sh8000_0000)) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: hdl/bone_world_transform.sv
// Top level of the bone world transform block.
`default_nettype none

// Skeletal forward kinematics in fixed point. Bones of a pass arrive in index
// order; each produces three result requests, the affine rows of its world
// matrix. One 32x32 multiplier is shared by all products, so a root bone passes
// through an accept step, nine quaternion products, nine scale products, the
// writing of its twelve world words into the store one word per cycle, and
// three row results. A bone with a valid parent adds 36 matrix products. A
// bone beyond capacity skips the twelve store writes. An output stall holds
// back the row results. The next request is taken once the last row of the
// previous bone sits in the output register.
module bone_world_transform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  input  logic signed [6:0]  parent_index_i,
  input  logic               last_bone_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         bone_index_o,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] col0_o,
  output logic signed [31:0] col1_o,
  output logic signed [31:0] col2_o,
  output logic signed [31:0] col3_o,
  output logic [1:0]         status_o,
  output logic               row_last_o,
  output logic               pass_end_o
);
  import bwt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  bwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Arithmetic and storage.
  bwt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .quat_w_i       (quat_w_i),
    .quat_x_i       (quat_x_i),
    .quat_y_i       (quat_y_i),
    .quat_z_i       (quat_z_i),
    .scale_x_i      (scale_x_i),
    .scale_y_i      (scale_y_i),
    .scale_z_i      (scale_z_i),
    .parent_index_i (parent_index_i),
    .last_bone_i    (last_bone_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .bone_index_o   (bone_index_o),
    .row_index_o    (row_index_o),
    .col0_o         (col0_o),
    .col1_o         (col1_o),
    .col2_o         (col2_o),
    .col3_o         (col3_o),
    .status_o       (status_o),
    .row_last_o     (row_last_o),
    .pass_end_o     (pass_end_o)
  );

endmodule

`default_nettype wire

// File: hdl/bwt_ctrl.sv
// Sequencer of the bone world transform: phases, step counters and handshakes.
`default_nettype none

module bwt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bwt_pkg::stat_t stat_i,
  output bwt_pkg::cmd_t  cmd_o
);
  import bwt_pkg::*;

  state_e     state_q, state_d;
  logic [1:0] row_q, row_d, col_q, col_d, k_q, k_d;
  logic [3:0] ld_q, ld_d, st_q, st_d;
  logic       grid_last, world_last, emit_go;

  assign grid_last  = (row_q == 2'd2) && (col_q == 2'd2);
  assign world_last = (row_q == 2'd2) && (col_q == 2'd3) && (k_q == 2'd2);
  assign emit_go    = (state_q == S_EMIT) && stat_i.out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_QUAT;
      S_QUAT:  if (grid_last) state_d = S_LOC;
      S_LOC: begin
        if (grid_last) begin
          if (stat_i.parent_ok) state_d = S_WORLD;
          else if (stat_i.full) state_d = S_EMIT;
          else                  state_d = S_STORE;
        end
      end
      S_WORLD: if (world_last) state_d = stat_i.full ? S_EMIT : S_STORE;
      S_STORE: if (st_q == 4'(MatWords - 1)) state_d = S_EMIT;
      S_EMIT:  if (emit_go && (row_q == 2'd2)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o         = '0;
    cmd_o.accept  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.row     = row_q;
    cmd_o.col     = col_q;
    cmd_o.k       = k_q;
    cmd_o.ld_idx  = ld_q;
    cmd_o.st_idx  = st_q;
    cmd_o.emit_en = emit_go;
    cmd_o.st_en   = (state_q == S_STORE);
    cmd_o.ld_en   = ((state_q == S_QUAT) || (state_q == S_LOC)) &&
                    (ld_q < 4'(MatWords)) && stat_i.parent_ok;
    unique case (state_q)
      S_QUAT:  cmd_o.phase = PH_QUAT;
      S_LOC:   cmd_o.phase = PH_LOC;
      S_WORLD: cmd_o.phase = PH_WORLD;
      default: cmd_o.phase = PH_NONE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  // Step counters.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    k_d   = k_q;
    ld_d  = ld_q;
    st_d  = st_q;
    unique case (state_q)
      S_IDLE: begin
        ld_d = '0;
      end
      S_QUAT, S_LOC: begin
        if (ld_q < 4'(MatWords)) ld_d = ld_q + 4'd1;
        if (grid_last) begin
          row_d = '0;
          col_d = '0;
        end else if (col_q == 2'd2) begin
          col_d = '0;
          row_d = row_q + 2'd1;
        end else begin
          col_d = col_q + 2'd1;
        end
      end
      S_WORLD: begin
        if (world_last) begin
          row_d = '0;
          col_d = '0;
          k_d   = '0;
        end else if (k_q == 2'd2) begin
          k_d = '0;
          if (col_q == 2'd3) begin
            col_d = '0;
            row_d = row_q + 2'd1;
          end else begin
            col_d = col_q + 2'd1;
          end
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      S_STORE: begin
        st_d = (st_q == 4'(MatWords - 1)) ? 4'd0 : st_q + 4'd1;
      end
      S_EMIT: begin
        if (emit_go) row_d = (row_q == 2'd2) ? 2'd0 : row_q + 2'd1;
      end
      default: begin
        row_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      k_q     <= '0;
      ld_q    <= '0;
      st_q    <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      k_q     <= k_d;
      ld_q    <= ld_d;
      st_q    <= st_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bwt_dp.sv
// Datapath: input capture, shared multiplier, matrix registers, world store, output row.
`default_nettype none

module bwt_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bwt_pkg::cmd_t        cmd_i,
  output bwt_pkg::stat_t       stat_o,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   pos_z_i,
  input  logic signed [15:0]   quat_w_i,
  input  logic signed [15:0]   quat_x_i,
  input  logic signed [15:0]   quat_y_i,
  input  logic signed [15:0]   quat_z_i,
  input  logic signed [31:0]   scale_x_i,
  input  logic signed [31:0]   scale_y_i,
  input  logic signed [31:0]   scale_z_i,
  input  logic signed [6:0]    parent_index_i,
  input  logic                 last_bone_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [5:0]           bone_index_o,
  output logic [1:0]           row_index_o,
  output logic signed [31:0]   col0_o,
  output logic signed [31:0]   col1_o,
  output logic signed [31:0]   col2_o,
  output logic signed [31:0]   col3_o,
  output logic [1:0]           status_o,
  output logic                 row_last_o,
  output logic                 pass_end_o
);
  import bwt_pkg::*;

  // Captured request.
  logic signed [31:0] t_q [3];
  logic signed [15:0] q_q [4];
  logic signed [31:0] s_q [3];
  logic [BoneIdxW-1:0] par_q, idx_q;
  logic                last_q, parent_ok_q, full_q;
  status_e             status_q;
  logic [BoneCntW-1:0] next_bone_q;

  // Intermediate matrices.
  logic signed [31:0] qp_q  [9];
  logic signed [31:0] loc_q [9];
  logic signed [31:0] pm_q  [MatWords];
  logic signed [31:0] w_q   [MatWords];
  logic signed [AccW-1:0] acc_q, acc_d;

  // Multiplier and its pipeline companion.
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_q;
  cmd_t               cmd_q;

  // World store.
  logic [31:0]      mem [MemDepth];
  logic [31:0]      rd_q;
  logic [AddrW-1:0] rd_addr, wr_addr;

  logic                parent_ok_n, full_n;
  logic signed [35:0]  r28;
  logic signed [35:0]  r28_rnd;
  logic signed [31:0]  rq;
  logic signed [31:0]  loc_val, world_val;
  logic signed [AccW-1:0] prod_ext, acc_base;
  logic [1:0]          qi0, qi1;

  // Classification of the incoming bone.
  assign full_n      = (next_bone_q >= BoneCntW'(MaxBones));
  assign parent_ok_n = !parent_index_i[6] &&
                       (BoneCntW'(parent_index_i[5:0]) < next_bone_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_bone_q <= '0;
      parent_ok_q <= 1'b0;
      full_q      <= 1'b0;
    end else if (cmd_i.accept) begin
      parent_ok_q <= parent_ok_n;
      full_q      <= full_n;
      if (last_bone_i)  next_bone_q <= '0;
      else if (!full_n) next_bone_q <= next_bone_q + BoneCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      t_q[0] <= pos_x_i;
      t_q[1] <= pos_y_i;
      t_q[2] <= pos_z_i;
      q_q[0] <= quat_w_i;
      q_q[1] <= quat_x_i;
      q_q[2] <= quat_y_i;
      q_q[3] <= quat_z_i;
      s_q[0] <= scale_x_i;
      s_q[1] <= scale_y_i;
      s_q[2] <= scale_z_i;
      par_q  <= parent_index_i[BoneIdxW-1:0];
      last_q <= last_bone_i;
      idx_q  <= full_n ? '0 : next_bone_q[BoneIdxW-1:0];
      if (full_n) begin
        status_q <= ST_FULL;
      end else if (parent_ok_n || (parent_index_i == -7'sd1)) begin
        status_q <= ST_OK;
      end else begin
        status_q <= ST_PARENT;
      end
    end
  end

  // Quaternion component pair for each of the nine products.
  always_comb begin
    unique case (idx9(cmd_i.row, cmd_i.col))
      4'd0:    begin qi0 = 2'd1; qi1 = 2'd1; end
      4'd1:    begin qi0 = 2'd2; qi1 = 2'd2; end
      4'd2:    begin qi0 = 2'd3; qi1 = 2'd3; end
      4'd3:    begin qi0 = 2'd1; qi1 = 2'd2; end
      4'd4:    begin qi0 = 2'd1; qi1 = 2'd3; end
      4'd5:    begin qi0 = 2'd2; qi1 = 2'd3; end
      4'd6:    begin qi0 = 2'd0; qi1 = 2'd1; end
      4'd7:    begin qi0 = 2'd0; qi1 = 2'd2; end
      default: begin qi0 = 2'd0; qi1 = 2'd3; end
    endcase
  end

  // Rotation entry in Q4.28 from the stored quaternion products.
  always_comb begin
    unique case (idx9(cmd_i.row, cmd_i.col))
      4'd0:    r28 = 36'sh1000_0000 - 36'sd2 * (36'(qp_q[1]) + 36'(qp_q[2]));
      4'd1:    r28 = 36'sd2 * (36'(qp_q[3]) - 36'(qp_q[8]));
      4'd2:    r28 = 36'sd2 * (36'(qp_q[4]) + 36'(qp_q[7]));
      4'd3:    r28 = 36'sd2 * (36'(qp_q[3]) + 36'(qp_q[8]));
      4'd4:    r28 = 36'sh1000_0000 - 36'sd2 * (36'(qp_q[0]) + 36'(qp_q[2]));
      4'd5:    r28 = 36'sd2 * (36'(qp_q[5]) - 36'(qp_q[6]));
      4'd6:    r28 = 36'sd2 * (36'(qp_q[4]) - 36'(qp_q[7]));
      4'd7:    r28 = 36'sd2 * (36'(qp_q[5]) + 36'(qp_q[6]));
      default: r28 = 36'sh1000_0000 - 36'sd2 * (36'(qp_q[0]) + 36'(qp_q[1]));
    endcase
    r28_rnd = (r28 + 36'sd2048) >>> 12;
    rq      = r28_rnd[31:0];
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd_i.phase)
      PH_QUAT: begin
        mul_a = 32'(q_q[qi0]);
        mul_b = 32'(q_q[qi1]);
      end
      PH_LOC: begin
        mul_a = rq;
        mul_b = s_q[cmd_i.col];
      end
      PH_WORLD: begin
        mul_a = pm_q[{cmd_i.row, cmd_i.k}];
        mul_b = (cmd_i.col == 2'd3) ? t_q[cmd_i.k] : loc_q[idx9(cmd_i.k, cmd_i.col)];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
    end else begin
      cmd_q <= cmd_i;
    end
  end

  // Rounding and accumulation of the product from the previous cycle.
  always_comb begin
    prod_ext  = AccW'(prod_q);
    loc_val   = sat32((prod_ext + AccW'(32768)) >>> 16);
    acc_base  = (cmd_q.col == 2'd3) ? (AccW'(pm_q[{cmd_q.row, 2'd3}]) <<< 16) : '0;
    acc_d     = (cmd_q.k == 2'd0) ? acc_base + prod_ext : acc_q + prod_ext;
    world_val = sat32((acc_d + AccW'(32768)) >>> 16);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      w_q[3]  <= pos_x_i;
      w_q[7]  <= pos_y_i;
      w_q[11] <= pos_z_i;
    end
    case (cmd_q.phase)
      PH_QUAT: qp_q[idx9(cmd_q.row, cmd_q.col)] <= prod_q[31:0];
      PH_LOC: begin
        loc_q[idx9(cmd_q.row, cmd_q.col)] <= loc_val;
        w_q[{cmd_q.row, cmd_q.col}]       <= loc_val;
      end
      PH_WORLD: begin
        acc_q <= acc_d;
        if (cmd_q.k == 2'd2) w_q[{cmd_q.row, cmd_q.col}] <= world_val;
      end
      default: ;
    endcase
    if (cmd_q.ld_en) pm_q[cmd_q.ld_idx] <= $signed(rd_q);
  end

  // World store: one read port for the parent, one write port for the result.
  assign rd_addr = AddrW'(par_q) * AddrW'(MatWords) + AddrW'(cmd_i.ld_idx);
  assign wr_addr = AddrW'(idx_q) * AddrW'(MatWords) + AddrW'(cmd_i.st_idx);

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
    if (cmd_i.st_en && !full_q) mem[wr_addr] <= w_q[cmd_i.st_idx];
  end

  // Output row register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit_en) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_en) begin
      bone_index_o <= idx_q;
      row_index_o  <= cmd_i.row;
      col0_o       <= w_q[{cmd_i.row, 2'd0}];
      col1_o       <= w_q[{cmd_i.row, 2'd1}];
      col2_o       <= w_q[{cmd_i.row, 2'd2}];
      col3_o       <= w_q[{cmd_i.row, 2'd3}];
      status_o     <= status_q;
      row_last_o   <= (cmd_i.row == 2'd2);
      pass_end_o   <= (cmd_i.row == 2'd2) && last_q;
    end
  end

  assign stat_o.parent_ok = parent_ok_q;
  assign stat_o.full      = full_q;
  assign stat_o.out_free  = !out_valid_o || !out_stall_i;

endmodule

`default_nettype wire

// File: hdl/bwt_checker.sv
// Port-level checks of the bone world transform and their binding.
`default_nettype none

module bwt_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [5:0]  bone_index_i,
  input logic [1:0]  row_index_i,
  input logic [31:0] col0_i,
  input logic [1:0]  status_i,
  input logic        row_last_i,
  input logic        pass_end_i
);
  import bwt_pkg::*;

  // A stalled result keeps its row.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(row_index_i) && $stable(col0_i))
    else $error("stalled result changed");

  // Only the third row ends a bone.
  a_row_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (row_last_i == (row_index_i == 2'd2)))
    else $error("row_last does not match row index");

  // The end of a pass only comes with the end of a bone.
  a_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && pass_end_i |-> row_last_i)
    else $error("pass_end without row_last");

  // Overflow bones report index zero, and no unknown status appears.
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (status_i == ST_OK || status_i == ST_PARENT ||
                     (status_i == ST_FULL && bone_index_i == 6'd0)))
    else $error("bad status or index");

endmodule

bind bone_world_transform bwt_props u_bwt_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .bone_index_i (bone_index_o),
  .row_index_i  (row_index_o),
  .col0_i       (col0_o),
  .status_i     (status_o),
  .row_last_i   (row_last_o),
  .pass_end_i   (pass_end_o)
);

`default_nettype wire

// File: tb/sv/bwt_checker.sv
// Checker for the bone world transform block: predicts world matrix rows and compares.
`timescale 1ns / 1ps

module bwt_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] quat_w_i,
  input  logic signed [15:0] quat_x_i,
  input  logic signed [15:0] quat_y_i,
  input  logic signed [15:0] quat_z_i,
  input  logic signed [31:0] scale_x_i,
  input  logic signed [31:0] scale_y_i,
  input  logic signed [31:0] scale_z_i,
  input  logic signed [6:0]  parent_index_i,
  input  logic               last_bone_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [5:0]         bone_index_i,
  input  logic [1:0]         row_index_i,
  input  logic signed [31:0] col0_i,
  input  logic signed [31:0] col1_i,
  input  logic signed [31:0] col2_i,
  input  logic signed [31:0] col3_i,
  input  logic [1:0]         status_i,
  input  logic               row_last_i,
  input  logic               pass_end_i,
  output int                 fail_count_o,
  output int                 rows_pending_o
);
  import bwt_pkg::*;

  localparam int RowSlots = 64;

  typedef struct packed {
    logic [5:0]         bone;
    logic [1:0]         row;
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    status_e            status;
    logic               row_last;
    logic               pass_end;
  } row_t;

  // Expected rows in a ring, filled by the predictor and drained in order.
  row_t               expected_rows[RowSlots];
  int                 wr_cnt;
  int                 rd_cnt;
  logic signed [31:0] world_mem[MaxBones*MatWords];
  int                 bone_count;
  int                 fails;

  assign fail_count_o   = fails;
  assign rows_pending_o = wr_cnt - rd_cnt;

  // Saturate a wide signed value to Q16.16 range.
  function automatic logic signed [31:0] clamp32(input logic signed [79:0] v);
    if (v > 80'sh7fff_ffff) return 32'sh7fff_ffff;
    if (v < -80'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Compute the world matrix of one bone request and queue its three rows.
  task automatic predict_bone();
    longint             q[4];
    longint             s[3];
    longint             r28[3][3];
    longint             rq;
    logic signed [31:0] loc[3][4];
    logic signed [31:0] wm[3][4];
    logic signed [79:0] acc;
    longint             par;
    logic               full, par_ok;
    status_e            st;
    int                 idx;
    row_t               e;
    q[0] = quat_w_i; q[1] = quat_x_i; q[2] = quat_y_i; q[3] = quat_z_i;
    s[0] = scale_x_i; s[1] = scale_y_i; s[2] = scale_z_i;
    par    = parent_index_i;
    full   = bone_count >= MaxBones;
    par_ok = par >= 0 && par < bone_count;
    st     = full ? ST_FULL : ((par == -1 || par_ok) ? ST_OK : ST_PARENT);
    idx    = full ? 0 : bone_count;

    // Rotation in Q4.28.
    r28[0][0] = (64'sd1 <<< 28) - 2 * (q[2]*q[2] + q[3]*q[3]);
    r28[0][1] = 2 * (q[1]*q[2] - q[0]*q[3]);
    r28[0][2] = 2 * (q[1]*q[3] + q[0]*q[2]);
    r28[1][0] = 2 * (q[1]*q[2] + q[0]*q[3]);
    r28[1][1] = (64'sd1 <<< 28) - 2 * (q[1]*q[1] + q[3]*q[3]);
    r28[1][2] = 2 * (q[2]*q[3] - q[0]*q[1]);
    r28[2][0] = 2 * (q[1]*q[3] - q[0]*q[2]);
    r28[2][1] = 2 * (q[2]*q[3] + q[0]*q[1]);
    r28[2][2] = (64'sd1 <<< 28) - 2 * (q[1]*q[1] + q[2]*q[2]);

    // Local matrix T*R*S.
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rq = (r28[r][c] + 2048) >>> 12;
        acc = (80'(rq) * 80'(s[c]) + 80'sd32768) >>> 16;
        loc[r][c] = clamp32(acc);
      end
    end
    loc[0][3] = pos_x_i; loc[1][3] = pos_y_i; loc[2][3] = pos_z_i;

    // Chain onto the parent, summed exactly and rounded once.
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (par_ok) begin
          acc = 0;
          for (int k = 0; k < 3; k++)
            acc += 80'(world_mem[par*12 + r*4 + k]) * 80'(loc[k][c]);
          if (c == 3) acc += 80'(world_mem[par*12 + r*4 + 3]) <<< 16;
          wm[r][c] = clamp32((acc + 80'sd32768) >>> 16);
        end else begin
          wm[r][c] = loc[r][c];
        end
      end
    end

    if (!full) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 4; c++)
          world_mem[bone_count*12 + r*4 + c] = wm[r][c];
      bone_count++;
    end
    if (last_bone_i) bone_count = 0;

    for (int r = 0; r < 3; r++) begin
      e.bone     = 6'(idx);
      e.row      = 2'(r);
      e.c0       = wm[r][0];
      e.c1       = wm[r][1];
      e.c2       = wm[r][2];
      e.c3       = wm[r][3];
      e.status   = st;
      e.row_last = (r == 2);
      e.pass_end = (r == 2) && last_bone_i;
      expected_rows[wr_cnt % RowSlots] = e;
      wr_cnt++;
    end
  endtask

  // Watch both channels; predict on input requests, compare on output requests.
  always @(posedge clk_i or negedge rst_ni) begin
    row_t e;
    if (!rst_ni) begin
      bone_count = 0;
      fails      = 0;
      wr_cnt     = 0;
      rd_cnt     = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_bone();
      if (out_valid_i && !out_stall_i) begin
        if (wr_cnt == rd_cnt) begin
          $display("%0t: unexpected row bone %0d row %0d", $time, bone_index_i, row_index_i);
          fails++;
        end else begin
          e = expected_rows[rd_cnt % RowSlots];
          rd_cnt++;
          if (e.bone !== bone_index_i || e.row !== row_index_i || e.c0 !== col0_i ||
              e.c1 !== col1_i || e.c2 !== col2_i || e.c3 !== col3_i ||
              e.status !== status_i || e.row_last !== row_last_i ||
              e.pass_end !== pass_end_i) begin
            $display("%0t: expected bone %0d row %0d cols %h %h %h %h st %0d last %b end %b",
                     $time, e.bone, e.row, e.c0, e.c1, e.c2, e.c3, e.status,
                     e.row_last, e.pass_end);
            $display("%0t: actual   bone %0d row %0d cols %h %h %h %h st %0d last %b end %b",
                     $time, bone_index_i, row_index_i, col0_i, col1_i, col2_i, col3_i,
                     status_i, row_last_i, pass_end_i);
            fails++;
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// Testbench top of the bone world transform block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import bwt_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic signed [31:0] scale_x = '0, scale_y = '0, scale_z = '0;
  logic signed [6:0]  parent_index = '0;
  logic               last_bone = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         bone_index;
  logic [1:0]         row_index;
  logic signed [31:0] col0, col1, col2, col3;
  logic [1:0]         status;
  logic               row_last, pass_end;
  int                 fail_count, rows_pending;
  int                 cycle_count = 0;
  int                 stall_left = 0;
  int                 bones_sent = 0;

  localparam int CycleLimit = 600000;

  always #4 clk = ~clk;

  bone_world_transform u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .quat_w_i(quat_w), .quat_x_i(quat_x), .quat_y_i(quat_y), .quat_z_i(quat_z),
    .scale_x_i(scale_x), .scale_y_i(scale_y), .scale_z_i(scale_z),
    .parent_index_i(parent_index), .last_bone_i(last_bone),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .bone_index_o(bone_index), .row_index_o(row_index),
    .col0_o(col0), .col1_o(col1), .col2_o(col2), .col3_o(col3),
    .status_o(status), .row_last_o(row_last), .pass_end_o(pass_end)
  );

  bwt_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .pos_x_i(pos_x), .pos_y_i(pos_y), .pos_z_i(pos_z),
    .quat_w_i(quat_w), .quat_x_i(quat_x), .quat_y_i(quat_y), .quat_z_i(quat_z),
    .scale_x_i(scale_x), .scale_y_i(scale_y), .scale_z_i(scale_z),
    .parent_index_i(parent_index), .last_bone_i(last_bone),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .bone_index_i(bone_index), .row_index_i(row_index),
    .col0_i(col0), .col1_i(col1), .col2_i(col2), .col3_i(col3),
    .status_i(status), .row_last_i(row_last), .pass_end_i(pass_end),
    .fail_count_o(fail_count), .rows_pending_o(rows_pending)
  );

  // Some stretches run with no idling on either side.
  function automatic int draw_wait();
    if ((cycle_count / 3000) % 4 == 1) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Cycle counter with a timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("bone_world_transform: mismatch");
      $finish;
    end
  end

  // Result receiver: stall a drawn number of cycles before each row.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        stall_left = draw_wait();
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Present one bone request after a drawn gap and wait for its acceptance.
  task automatic send_bone(input logic signed [31:0] px, py, pz,
                           input logic signed [15:0] qw, qx, qy, qz,
                           input logic signed [31:0] sx, sy, sz,
                           input logic signed [6:0] par, input logic last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
    scale_x <= sx; scale_y <= sy; scale_z <= sz;
    parent_index <= par; last_bone <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bones_sent++;
  endtask

  // A Q16.16 value: mostly modest, sometimes any bit pattern.
  function automatic logic signed [31:0] rand_q16();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed(32'($urandom_range(0, 524288))) - 32'sd262144;
  endfunction

  // A quaternion component: mostly within unit range, sometimes anything.
  function automatic logic signed [15:0] rand_quat();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
  endfunction

  // Parent choice: mostly an earlier bone or root, sometimes a bad index.
  function automatic logic signed [6:0] rand_parent(input int idx);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      if ($urandom_range(0, 1) == 0 && idx <= 63) return 7'($urandom_range(idx, 63));
      return -7'sd2 - 7'($urandom_range(0, 62));
    end
    if (idx == 0 || pick < 30) return -7'sd1;
    return 7'($urandom_range(0, idx - 1));
  endfunction

  // Send one skeleton pass of random bones.
  task automatic send_pass(input int len);
    for (int i = 0; i < len; i++)
      send_bone(rand_q16(), rand_q16(), rand_q16(), rand_quat(), rand_quat(), rand_quat(),
                rand_quat(), rand_q16(), rand_q16(), rand_q16(), rand_parent(i), i == len - 1);
  endtask

  // Stimulus and verdict.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity root, field extremes, chains and bad parents.
    send_bone(0, 0, 0, 16'sd16384, 0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, -7'sd1, 0);
    send_bone(32'sh7fff_ffff, 32'sh8000_0000, 32'sh10000, 16'sd16384, 0, 0, 0,
              32'sh7fff_ffff, 32'sh8000_0000, 32'sh10000, 7'sd0, 0);
    send_bone(32'sh8000_0000, 32'sh7fff_ffff, 0, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 7'sd1, 0);
    send_bone(32'sh10000, 32'sh20000, 32'sh30000, 16'sd11585, 16'sd11585, 0, 0,
              32'sh20000, 32'sh8000, 32'sh10000, 7'sd2, 0);
    send_bone(0, 0, 0, 0, 0, 0, 16'sd16384, 32'sh10000, 32'sh10000, 32'sh10000, 7'sd63, 0);
    send_bone(32'sh1234, 0, 0, 16'sd16384, 0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
              7'sd5, 0);
    send_bone(0, 32'sh5678, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
              32'sh10000, 32'sh10000, 32'sh10000, -7'sd64, 0);
    send_bone(0, 0, 32'sh7fff_ffff, 16'sd16384, 0, 0, 0, 0, 0, 0, -7'sd2, 0);
    send_bone(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 16'sd16384, 0, 0, 0,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 7'sd1, 0);
    send_bone(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 16'sd16384, 0, 0, 0,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 7'sd8, 1);
    // A single-bone pass, then a pass whose first bone names a stale slot as its parent.
    send_bone(32'sh10000, 0, 0, 0, 16'sd16384, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000,
              -7'sd1, 1);
    send_bone(0, 0, 0, 16'sd16384, 0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 7'sd0, 0);
    send_bone(0, 0, 0, 16'sd16384, 0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 7'sd0, 1);

    // Random: short passes, plus one pass running past capacity.
    send_pass(70);
    while (bones_sent < 300) send_pass($urandom_range(1, 12));
    in_valid <= 1'b0;

    // Let the checker see the last accepted request before draining.
    @(posedge clk);
    while (rows_pending > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("bone_world_transform: match");
    end else begin
      $display("bone_world_transform: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/bwt_pkg.sv
hdl/bwt_ctrl.sv
hdl/bwt_dp.sv
hdl/bone_world_transform.sv
hdl/bwt_checker.sv
tb/sv/bwt_checker.sv
tb/sv/tb_top.sv
